// ===== rtl/core/afrg_pkg.sv =====
// ----------------------------------------------------------------------------
// Adaptive frame rate governor package
// Widths, register indexes, reset values, the command and status structs
// between controller and datapath, and the rate ladder functions.
// ----------------------------------------------------------------------------
package afrg_pkg;

	localparam int FT_W      = 20;
	localparam int RATE_W    = 8;
	localparam int CNT_W     = 16;
	localparam int SUM_W     = 25;
	localparam int WIN_W     = 10;
	localparam int THR_W     = 11;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = CNT_W + THR_W;
	localparam int QCMP_W    = 28;
	localparam int DIV_STEPS = FT_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAISE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MONITOR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START    = 3'd5;

	localparam logic [WIN_W-1:0]  WINDOW_RST   = 10'd90;
	localparam logic [WIN_W-1:0]  COOLDOWN_RST = 10'd180;
	localparam logic [THR_W-1:0]  LOWER_RST    = 11'd102;
	localparam logic [THR_W-1:0]  RAISE_RST    = 11'd20;
	localparam logic [RATE_W-1:0] MONITOR_RST  = 8'd60;
	localparam logic [RATE_W-1:0] START_RST    = 8'd60;

	localparam int US_PER_S_INT = 1000000;
	localparam logic [FT_W-1:0]   US_PER_S    = FT_W'(US_PER_S_INT);
	localparam logic [FT_W-1:0]   TARGET_RST  = FT_W'(US_PER_S_INT / 60);
	localparam logic [FT_W:0]     MISS_TOL_US = 21'd3000;
	localparam logic [CNT_W-1:0]  CNT_MAX     = 16'hFFFF;

	localparam logic [RATE_W-1:0] RATE_30  = 8'd30;
	localparam logic [RATE_W-1:0] RATE_45  = 8'd45;
	localparam logic [RATE_W-1:0] RATE_60  = 8'd60;
	localparam logic [RATE_W-1:0] RATE_90  = 8'd90;
	localparam logic [RATE_W-1:0] RATE_120 = 8'd120;

	typedef struct packed {
		logic capture;
		logic record;
		logic mult;
		logic decide;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_busy;
	} dp_stat_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
	endfunction

	function automatic logic [RATE_W-1:0] rate_up(input logic [RATE_W-1:0] cur,
			input logic [RATE_W-1:0] mon);
		logic [RATE_W-1:0] n;
		unique case (cur)
			RATE_30: n = RATE_45;
			RATE_45: n = RATE_60;
			RATE_60: n = RATE_90;
			RATE_90: n = RATE_120;
			default: n = mon;
		endcase
		return (n > mon) ? mon : n;
	endfunction

	function automatic logic [RATE_W-1:0] rate_down(input logic [RATE_W-1:0] cur);
		logic [RATE_W-1:0] n;
		unique case (cur)
			RATE_120: n = RATE_90;
			RATE_90:  n = RATE_60;
			RATE_60:  n = RATE_45;
			default:  n = RATE_30;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/core/afrg_div.sv =====
// ----------------------------------------------------------------------------
// Frame period divider
// Restoring divider that computes one million microseconds divided by the
// frame rate, one quotient bit per cycle. A rate of zero yields all ones.
// ----------------------------------------------------------------------------
module afrg_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [afrg_pkg::RATE_W-1:0] divisor,
	output logic                        busy,
	output logic                        done,
	output logic [afrg_pkg::FT_W-1:0]   quotient
);

	logic [afrg_pkg::RATE_W-1:0] rem_q;
	logic [afrg_pkg::RATE_W-1:0] dvs_q;
	logic [afrg_pkg::FT_W-1:0]   quo_q;
	logic [afrg_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [afrg_pkg::RATE_W:0]   shifted;
	logic [afrg_pkg::RATE_W:0]   diff;
	logic                        ge;

	assign shifted = {rem_q, quo_q[afrg_pkg::FT_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= afrg_pkg::DCNT_W'(afrg_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - afrg_pkg::DCNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= afrg_pkg::US_PER_S;
		end else if (busy_q) begin
			rem_q <= ge ? diff[afrg_pkg::RATE_W-1:0] : shifted[afrg_pkg::RATE_W-1:0];
			quo_q <= {quo_q[afrg_pkg::FT_W-2:0], ge};
		end
	end

	assign busy     = busy_q | done_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/afrg_dp.sv =====
// ----------------------------------------------------------------------------
// Adaptive frame rate governor datapath
// Frame history ring and running sum, frame counters, miss rate products,
// the raise and lower decision and the result word register.
// ----------------------------------------------------------------------------
module afrg_dp #(
	parameter int HISTORY_DEPTH  = 10,
	parameter int QUICK_GOOD_RUN = 30,
	parameter int QUICK_SETTLE   = 90
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  afrg_pkg::ctrl_cmd_t          cmd,
	output afrg_pkg::dp_stat_t           stat,
	input  logic [afrg_pkg::FT_W-1:0]    frame_time_us,
	input  logic [afrg_pkg::WIN_W-1:0]   window_frames,
	input  logic [afrg_pkg::WIN_W-1:0]   settle_frames,
	input  logic [afrg_pkg::THR_W-1:0]   lower_threshold,
	input  logic [afrg_pkg::THR_W-1:0]   raise_threshold,
	input  logic [afrg_pkg::RATE_W-1:0]  monitor_rate_hz,
	output logic [afrg_pkg::RATE_W-1:0]  rate_hz,
	output logic                         rate_changed,
	output logic                         went_up,
	output logic                         was_missed
);

	localparam int PW = $clog2(HISTORY_DEPTH);

	logic [afrg_pkg::FT_W-1:0]   ft_q;
	logic [afrg_pkg::FT_W-1:0]   hist_q [HISTORY_DEPTH];
	logic [PW-1:0]               pos_q;
	logic [afrg_pkg::SUM_W-1:0]  sum_q;
	logic [afrg_pkg::RATE_W-1:0] rate_q;
	logic [afrg_pkg::FT_W-1:0]   target_q;
	logic [afrg_pkg::CNT_W-1:0]  sampled_q;
	logic [afrg_pkg::CNT_W-1:0]  missed_cnt_q;
	logic [afrg_pkg::CNT_W-1:0]  since_q;
	logic [afrg_pkg::CNT_W-1:0]  good_q;
	logic                        missed_q;
	logic                        changed_q;
	logic                        up_q;
	logic [afrg_pkg::PROD_W-1:0] miss_x_q;
	logic [afrg_pkg::PROD_W-1:0] raise_p_q;
	logic [afrg_pkg::PROD_W-1:0] lower_p_q;
	logic [afrg_pkg::QCMP_W-1:0] sum5_q;
	logic [afrg_pkg::QCMP_W-1:0] tgt_q;
	logic [afrg_pkg::RATE_W-1:0] out_rate_q;
	logic                        out_changed_q;
	logic                        out_up_q;
	logic                        out_missed_q;

	logic                        miss_now;
	logic                        window_full;
	logic                        settled;
	logic                        below_mon;
	logic                        quick_ok;
	logic                        regular_ok;
	logic                        do_raise;
	logic                        do_lower;
	logic [afrg_pkg::RATE_W-1:0] next_rate;
	logic                        change;
	logic                        div_busy;
	logic                        div_done;
	logic [afrg_pkg::FT_W-1:0]   div_quo;

	assign miss_now    = {1'b0, ft_q} > ({1'b0, target_q} + afrg_pkg::MISS_TOL_US);
	assign window_full = sampled_q >= afrg_pkg::CNT_W'(window_frames);
	assign settled     = since_q >= afrg_pkg::CNT_W'(settle_frames);
	assign below_mon   = rate_q < monitor_rate_hz;
	assign quick_ok    = (good_q >= afrg_pkg::CNT_W'(QUICK_GOOD_RUN)) && below_mon
		&& (since_q >= afrg_pkg::CNT_W'(QUICK_SETTLE)) && (sum5_q < tgt_q);
	assign regular_ok  = window_full && settled && (miss_x_q < raise_p_q) && below_mon;
	assign do_raise    = quick_ok || regular_ok;
	assign do_lower    = !do_raise && window_full && settled && (miss_x_q > lower_p_q);
	assign next_rate   = do_raise ? afrg_pkg::rate_up(rate_q, monitor_rate_hz)
		: afrg_pkg::rate_down(rate_q);
	assign change      = (do_raise || do_lower) && (next_rate != rate_q);

	afrg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.decide && change),
		.divisor  (next_rate),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			pos_q        <= '0;
			sum_q        <= '0;
			rate_q       <= afrg_pkg::START_RST;
			target_q     <= afrg_pkg::TARGET_RST;
			sampled_q    <= '0;
			missed_cnt_q <= '0;
			since_q      <= '0;
			good_q       <= '0;
		end else begin
			if (cmd.record) begin
				hist_q[pos_q] <= ft_q;
				sum_q         <= sum_q - afrg_pkg::SUM_W'(hist_q[pos_q])
					+ afrg_pkg::SUM_W'(ft_q);
				pos_q         <= (pos_q == PW'(HISTORY_DEPTH - 1)) ? '0 : pos_q + PW'(1);
				sampled_q     <= afrg_pkg::sat_inc(sampled_q);
				since_q       <= afrg_pkg::sat_inc(since_q);
				if (miss_now) begin
					missed_cnt_q <= afrg_pkg::sat_inc(missed_cnt_q);
					good_q       <= '0;
				end else begin
					good_q <= afrg_pkg::sat_inc(good_q);
				end
			end
			if (cmd.decide) begin
				if (change) begin
					rate_q       <= next_rate;
					sampled_q    <= '0;
					missed_cnt_q <= '0;
					since_q      <= '0;
					good_q       <= '0;
				end else if (!do_raise && !do_lower && window_full) begin
					sampled_q    <= '0;
					missed_cnt_q <= '0;
				end
			end
			if (div_done) begin
				target_q <= div_quo;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ft_q <= frame_time_us;
		end
		if (cmd.record) begin
			missed_q <= miss_now;
		end
		if (cmd.mult) begin
			miss_x_q  <= afrg_pkg::PROD_W'({missed_cnt_q, 10'b0});
			raise_p_q <= afrg_pkg::PROD_W'(raise_threshold) * afrg_pkg::PROD_W'(sampled_q);
			lower_p_q <= afrg_pkg::PROD_W'(lower_threshold) * afrg_pkg::PROD_W'(sampled_q);
			sum5_q    <= afrg_pkg::QCMP_W'(sum_q) * afrg_pkg::QCMP_W'(5);
			tgt_q     <= afrg_pkg::QCMP_W'(target_q) * afrg_pkg::QCMP_W'(4 * HISTORY_DEPTH);
		end
		if (cmd.decide) begin
			changed_q <= change;
			up_q      <= change && do_raise;
		end
		if (cmd.load_out) begin
			out_rate_q    <= rate_q;
			out_changed_q <= changed_q;
			out_up_q      <= up_q;
			out_missed_q  <= missed_q;
		end
	end

	assign stat.div_busy = div_busy;
	assign rate_hz       = out_rate_q;
	assign rate_changed  = out_changed_q;
	assign went_up       = out_up_q;
	assign was_missed    = out_missed_q;

endmodule

// ===== rtl/core/afrg_ctrl.sv =====
// ----------------------------------------------------------------------------
// Adaptive frame rate governor controller
// Sequences one frame word through record, multiply, decide and divide, and
// owns the input stall and the output valid.
// ----------------------------------------------------------------------------
module afrg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output afrg_pkg::ctrl_cmd_t cmd,
	input  afrg_pkg::dp_stat_t  stat
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_REC  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DEC  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       can_load;

	assign can_load = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_REC;
				end
			end
			ST_REC: begin
				cmd.record = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.mult = 1'b1;
				state_d  = ST_DEC;
			end
			ST_DEC: begin
				cmd.decide = 1'b1;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				if (!stat.div_busy) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (can_load) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/adaptive_frame_rate_governor.sv =====
// ----------------------------------------------------------------------------
// Adaptive frame rate governor
// Takes one measured frame time per word and answers with the frame rate in
// force, whether it changed, its direction and whether the frame was missed.
// ----------------------------------------------------------------------------
// One frame word is handled at a time: a word passes through capture, record,
// multiply, decide, a divider wait and the result load, and when the rate
// changes the new target period is computed in the wait by a restoring divider
// that yields one quotient bit per cycle. The input is stalled from acceptance
// until the result is loaded into the output register; a loaded result may wait
// there while the next word is accepted. Configuration writes are always ready.
module adaptive_frame_rate_governor #(
	parameter int HISTORY_DEPTH  = 10,
	parameter int QUICK_GOOD_RUN = 30,
	parameter int QUICK_SETTLE   = 90
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [afrg_pkg::FT_W-1:0]        frame_time_us,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [afrg_pkg::RATE_W-1:0]      rate_hz,
	output logic                             rate_changed,
	output logic                             went_up,
	output logic                             was_missed,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [afrg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [afrg_pkg::THR_W-1:0]       cfg_data
);

	logic [afrg_pkg::WIN_W-1:0]  window_q;
	logic [afrg_pkg::WIN_W-1:0]  cooldown_q;
	logic [afrg_pkg::THR_W-1:0]  lower_q;
	logic [afrg_pkg::THR_W-1:0]  raise_q;
	logic [afrg_pkg::RATE_W-1:0] monitor_q;
	afrg_pkg::ctrl_cmd_t         cmd;
	afrg_pkg::dp_stat_t          stat;

	assign cfg_ready = 1'b1;

	// The start rate only matters at reset, where it reloads its fixed value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= afrg_pkg::WINDOW_RST;
			cooldown_q <= afrg_pkg::COOLDOWN_RST;
			lower_q    <= afrg_pkg::LOWER_RST;
			raise_q    <= afrg_pkg::RAISE_RST;
			monitor_q  <= afrg_pkg::MONITOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				afrg_pkg::REG_WINDOW:   window_q   <= cfg_data[afrg_pkg::WIN_W-1:0];
				afrg_pkg::REG_COOLDOWN: cooldown_q <= cfg_data[afrg_pkg::WIN_W-1:0];
				afrg_pkg::REG_LOWER:    lower_q    <= cfg_data;
				afrg_pkg::REG_RAISE:    raise_q    <= cfg_data;
				afrg_pkg::REG_MONITOR:  monitor_q  <= cfg_data[afrg_pkg::RATE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	afrg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	afrg_dp #(
		.HISTORY_DEPTH  (HISTORY_DEPTH),
		.QUICK_GOOD_RUN (QUICK_GOOD_RUN),
		.QUICK_SETTLE   (QUICK_SETTLE)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.frame_time_us   (frame_time_us),
		.window_frames   (window_q),
		.settle_frames   (cooldown_q),
		.lower_threshold (lower_q),
		.raise_threshold (raise_q),
		.monitor_rate_hz (monitor_q),
		.rate_hz         (rate_hz),
		.rate_changed    (rate_changed),
		.went_up         (went_up),
		.was_missed      (was_missed)
	);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.record, cmd.mult, cmd.decide, cmd.load_out}))
		else $error("more than one datapath command at once");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled while a word is in process");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("result loaded without output valid");

	a_div_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_busy |-> in_stall)
		else $error("input open while the divider runs");

endmodule
